// ===== src/usf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_pkg
// Shared types, constants and helpers of the utf-8 byte sanitizer.
// ----------------------------------------------------------------------------
package usf_pkg;

   // width of the saturating replaced-byte counter
   localparam int COUNT_WIDTH = 16;
   localparam int TOTAL_WIDTH = 16;

   // entries of the queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // byte classes
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_TAG    = 8'h80;
   localparam logic [7:0] LEAD2_LO    = 8'hC2;
   localparam logic [7:0] LEAD2_HI    = 8'hDF;
   localparam logic [7:0] LEAD3_LO    = 8'hE0;
   localparam logic [7:0] LEAD3_HI    = 8'hEF;
   localparam logic [7:0] LEAD4_LO    = 8'hF0;
   localparam logic [7:0] LEAD4_HI    = 8'hF4;
   localparam logic [7:0] QMARK       = 8'h3F;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   // one run of up to four result bytes caused by one input item
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [3:0]      bad;
      logic [1:0]      last;
      logic            fin;
   } desc_type;

   // push side of the queue
   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   // character length opened by a lead byte, zero when not a lead byte
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
      else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
      else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
      return len;
   endfunction

   // counter value as shown in the result field, clamped at its width
   function automatic logic [TOTAL_WIDTH-1:0] to_total(input logic [COUNT_WIDTH-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      if (w > 32'(16'hFFFF)) return 16'hFFFF;
      return w[TOTAL_WIDTH-1:0];
   endfunction

endpackage

// ===== src/usf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_front
// Accepts input bytes, tracks the open character and builds one run
// descriptor per input item that causes results.
// ----------------------------------------------------------------------------
module usf_front import usf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   input  logic       q_full,
   output push_type   push
);

   logic [7:0] held_bytes_ff [3];
   logic [7:0] held_bytes_in [3];
   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] char_length_ff, char_length_in;
   logic       accept;
   logic [2:0] n_res;
   logic       done;
   logic [2:0] lead_len;
   desc_type   d;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign lead_len  = lead_length(req_data_byte);

   // classify the byte and collect the results it causes
   always_comb begin
      d              = '0;
      n_res          = 3'd0;
      done           = 1'b0;
      held_bytes_in  = held_bytes_ff;
      held_count_in  = held_count_ff;
      char_length_in = char_length_ff;

      if (held_count_ff != 2'd0) begin
         if ((req_data_byte & CONT_MASK) == CONT_TAG) begin
            done = 1'b1;
            if (({1'b0, held_count_ff} + 3'd1) >= char_length_ff) begin
               // character complete: held bytes then this one
               for (int k = 0; k < 3; k++) begin
                  if (k < 32'(held_count_ff) && n_res < 3'd4) begin
                     d.bytes[n_res[1:0]] = held_bytes_ff[k];
                     d.bad[n_res[1:0]]   = 1'b0;
                     n_res = n_res + 3'd1;
                  end
               end
               if (n_res < 3'd4) begin
                  d.bytes[n_res[1:0]] = req_data_byte;
                  d.bad[n_res[1:0]]   = 1'b0;
                  n_res = n_res + 3'd1;
               end
               held_count_in  = 2'd0;
               char_length_in = 3'd0;
            end else if (held_count_ff < 2'd3) begin
               held_bytes_in[held_count_ff] = req_data_byte;
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            // broken character: every held byte is replaced
            for (int k = 0; k < 3; k++) begin
               if (k < 32'(held_count_ff) && n_res < 3'd4) begin
                  d.bytes[n_res[1:0]] = QMARK;
                  d.bad[n_res[1:0]]   = 1'b1;
                  n_res = n_res + 3'd1;
               end
            end
            held_count_in  = 2'd0;
            char_length_in = 3'd0;
         end
      end

      // parse the byte afresh
      if (!done) begin
         if (req_data_byte < ASCII_LIMIT) begin
            if (n_res < 3'd4) begin
               d.bytes[n_res[1:0]] = req_data_byte;
               d.bad[n_res[1:0]]   = 1'b0;
               n_res = n_res + 3'd1;
            end
         end else if (lead_len != 3'd0) begin
            held_bytes_in[0] = req_data_byte;
            held_count_in    = 2'd1;
            char_length_in   = lead_len;
         end else if (n_res < 3'd4) begin
            d.bytes[n_res[1:0]] = QMARK;
            d.bad[n_res[1:0]]   = 1'b1;
            n_res = n_res + 3'd1;
         end
      end

      // text ends with a character still open
      if (req_final_byte && held_count_in != 2'd0) begin
         for (int k = 0; k < 3; k++) begin
            if (k < 32'(held_count_in) && n_res < 3'd4) begin
               d.bytes[n_res[1:0]] = QMARK;
               d.bad[n_res[1:0]]   = 1'b1;
               n_res = n_res + 3'd1;
            end
         end
         held_count_in  = 2'd0;
         char_length_in = 3'd0;
      end

      d.last = 2'(n_res - 3'd1);
      d.fin  = req_final_byte;
   end

   assign push.valid = accept && (n_res != 3'd0);
   assign push.desc  = d;

   // character state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff  <= 2'd0;
         char_length_ff <= 3'd0;
      end else if (accept) begin
         held_count_ff  <= held_count_in;
         char_length_ff <= char_length_in;
      end
   end

   // held bytes, payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         held_bytes_ff <= held_bytes_in;
      end
   end

endmodule

// ===== src/usf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_queue
// Short queue of run descriptors between front and back.
// ----------------------------------------------------------------------------
module usf_queue import usf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output desc_type head
);

   desc_type          entries_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // fill level
   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) count_in = count_ff + QCNT_W'(1);
      else if (!push.valid && do_pop) count_in = count_ff - QCNT_W'(1);
   end

   // pointers and level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.desc;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("descriptor pushed into a full queue");

   a_level_grows: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !do_pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue level did not grow on push");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue level beyond depth");
`endif

endmodule

// ===== src/usf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usf_back
// Walks the head descriptor one byte per cycle into the result register
// while it is empty or taken, and keeps the saturating replaced-byte count.
// ----------------------------------------------------------------------------
module usf_back import usf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  desc_type               head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_was_replaced,
   output logic                   rsp_run_end,
   output logic                   rsp_text_end,
   output logic [TOTAL_WIDTH-1:0] rsp_bad_total
);

   logic                   rsp_valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   replaced_ff;
   logic                   run_end_ff;
   logic                   text_end_ff;
   logic [TOTAL_WIDTH-1:0] total_ff;
   logic [1:0]             idx_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   load;
   logic                   cur_bad;
   logic                   cur_last;

   assign load     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign cur_bad  = head.bad[idx_ff];
   assign cur_last = (idx_ff == head.last);
   assign pop      = load && cur_last;

   // count including the byte now loaded
   always_comb begin
      cnt_in = cnt_ff;
      if (cur_bad && cnt_ff != CNT_MAX) cnt_in = cnt_ff + COUNT_WIDTH'(1);
   end

   // control: valid, position in run, counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         cnt_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            if (cur_last) begin
               idx_ff <= 2'd0;
               cnt_ff <= head.fin ? '0 : cnt_in;
            end else begin
               idx_ff <= idx_ff + 2'd1;
               cnt_ff <= cnt_in;
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= head.bytes[idx_ff];
         replaced_ff <= cur_bad;
         run_end_ff  <= cur_last;
         text_end_ff <= cur_last && head.fin;
         total_ff    <= to_total(cnt_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_was_replaced = replaced_ff;
   assign rsp_run_end      = run_end_ff;
   assign rsp_text_end     = text_end_ff;
   assign rsp_bad_total    = total_ff;

endmodule

// ===== src/utf8_byte_sanitizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer
// Byte-wise utf-8 validation: valid characters pass, broken ones and stray
// bytes become '?', with a saturating count of replaced bytes.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake        payload
//  req_     in         valid / ready    data_byte, final_byte
//  rsp_     out        valid / ready    out_byte, was_replaced, run_end,
//                                       text_end, bad_total
//
// One input item is taken per cycle while the descriptor queue (4 runs)
// has room; the front classifies it in the same cycle.
// Results leave one per cycle from the result register while rsp_ready
// is high, loaded from the run at the queue head; an input that ends a
// character or breaks one yields up to four results.
// Reset is synchronous and clears the character state, queue and counter.
// A stalled result side fills the queue and then drops req_ready.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer import usf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_final_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_was_replaced,
   output logic                   rsp_run_end,
   output logic                   rsp_text_end,
   output logic [TOTAL_WIDTH-1:0] rsp_bad_total
);

   push_type push;
   logic     q_full;
   logic     q_pop;
   logic     q_head_valid;
   desc_type q_head;

   // front: accept and classify
   usf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .push           (push)
   );

   // run queue
   usf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // back: emit results
   usf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head             (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_was_replaced (rsp_was_replaced),
      .rsp_run_end      (rsp_run_end),
      .rsp_text_end     (rsp_text_end),
      .rsp_bad_total    (rsp_bad_total)
   );

endmodule
